>>> sv/mas_pkg.sv
// ----------------------------------------------------------------------------
// mas_pkg
// Shared types, codes and helpers of the misaligned access splitter.
// ----------------------------------------------------------------------------
package mas_pkg;

  localparam int MAX_ACCESS_BYTES = 8;
  localparam int BYTE_IDX_W       = $clog2(MAX_ACCESS_BYTES);
  localparam int LEN_W            = $clog2(MAX_ACCESS_BYTES + 1);
  localparam int QUEUE_DEPTH      = 2;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_XLEN_IS_64      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FP_EMULATION_ON = 2'd1;

  // result kinds
  localparam logic [2:0] KIND_READ    = 3'd0;
  localparam logic [2:0] KIND_WRITE   = 3'd1;
  localparam logic [2:0] KIND_INT_WB  = 3'd2;
  localparam logic [2:0] KIND_FP_WB   = 3'd3;
  localparam logic [2:0] KIND_ILLEGAL = 3'd4;

  // input actions
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_BYTE  = 1'b1;

  // opcodes and funct3 codes
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_LOAD_FP  = 7'h07;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_STORE_FP = 7'h27;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_D  = 3'd3;
  localparam logic [2:0] F3_HU = 3'd5;
  localparam logic [2:0] F3_WU = 3'd6;

  localparam logic [LEN_W-1:0] LEN_NONE   = LEN_W'(0);
  localparam logic [LEN_W-1:0] LEN_HALF   = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_WORD   = LEN_W'(4);
  localparam logic [LEN_W-1:0] LEN_DOUBLE = LEN_W'(8);

  // load flag bits
  localparam int FLAG_SIGNED = 0;
  localparam int FLAG_FP     = 1;

  typedef struct packed {
    logic        action;
    logic        trap_is_store;
    logic [31:0] instruction;
    logic [63:0] fault_address;
    logic [63:0] trap_pc;
    logic [63:0] int_source_value;
    logic [63:0] fp_source_value;
    logic [7:0]  loaded_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [63:0] byte_address;
    logic [7:0]  byte_to_write;
    logic [4:0]  dest_register;
    logic [63:0] writeback_value;
    logic        fp_is_double;
    logic [63:0] resume_pc;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic xlen_is_64;
    logic fp_emulation_on;
  } cfg_t;

  typedef enum logic [1:0] {
    JOB_WRITE,
    JOB_READ,
    JOB_ILLEGAL,
    JOB_BYTE
  } job_op_t;

  // classified work item between front and back
  typedef struct packed {
    job_op_t          op;
    logic [LEN_W-1:0] len;
    logic [63:0]      addr;
    logic [63:0]      data;   // store data, or the loaded byte in bits 7:0
    logic [4:0]       rd;
    logic [1:0]       flags;
    logic [63:0]      pc;     // resume pc, or trap pc for an illegal job
  } job_t;

  function automatic logic [63:0] xmask(input logic xlen_is_64);
    xmask = xlen_is_64 ? {64{1'b1}} : {32'h0000_0000, 32'hFFFF_FFFF};
  endfunction

endpackage

>>> sv/mas_front.sv
// ----------------------------------------------------------------------------
// mas_front
// Takes input items and classifies them into jobs for the back end.
// ----------------------------------------------------------------------------
module mas_front (
  input  mas_pkg::cfg_t     cfg,
  input  logic              in_push,
  input  mas_pkg::in_item_t in_data,
  output logic              in_full,
  input  logic              queue_full,
  output logic              job_push,
  output mas_pkg::job_t     job
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [63:0] m;
  logic [63:0] pc;
  logic [63:0] iv;
  logic [mas_pkg::LEN_W-1:0] len;
  logic [1:0]  flags;
  logic [63:0] data;

  assign in_full  = queue_full;
  assign job_push = in_push && !queue_full;

  assign opc = in_data.instruction[6:0];
  assign f3  = in_data.instruction[14:12];
  assign m   = mas_pkg::xmask(cfg.xlen_is_64);
  assign pc  = in_data.trap_pc & m;
  assign iv  = in_data.int_source_value & m;

  always_comb begin
    len   = mas_pkg::LEN_NONE;
    flags = 2'b00;
    data  = 64'h0;
    if (in_data.trap_is_store) begin
      if (opc == mas_pkg::OPC_STORE && f3 == mas_pkg::F3_W) begin
        len  = mas_pkg::LEN_WORD;
        data = iv;
      end else if (opc == mas_pkg::OPC_STORE && f3 == mas_pkg::F3_D && cfg.xlen_is_64) begin
        len  = mas_pkg::LEN_DOUBLE;
        data = iv;
      end else if (opc == mas_pkg::OPC_STORE_FP && f3 == mas_pkg::F3_D
                   && cfg.fp_emulation_on) begin
        len  = mas_pkg::LEN_DOUBLE;
        data = in_data.fp_source_value;
      end else if (opc == mas_pkg::OPC_STORE_FP && f3 == mas_pkg::F3_W
                   && cfg.fp_emulation_on) begin
        len  = mas_pkg::LEN_WORD;
        data = in_data.fp_source_value;
      end else if (opc == mas_pkg::OPC_STORE && f3 == mas_pkg::F3_H) begin
        len  = mas_pkg::LEN_HALF;
        data = iv;
      end
    end else begin
      if (opc == mas_pkg::OPC_LOAD && f3 == mas_pkg::F3_W) begin
        len   = mas_pkg::LEN_WORD;
        flags = 2'b01;
      end else if (opc == mas_pkg::OPC_LOAD && f3 == mas_pkg::F3_D && cfg.xlen_is_64) begin
        len   = mas_pkg::LEN_DOUBLE;
        flags = 2'b01;
      end else if (opc == mas_pkg::OPC_LOAD && f3 == mas_pkg::F3_WU && cfg.xlen_is_64) begin
        len   = mas_pkg::LEN_WORD;
      end else if (opc == mas_pkg::OPC_LOAD_FP && f3 == mas_pkg::F3_D
                   && cfg.fp_emulation_on) begin
        len   = mas_pkg::LEN_DOUBLE;
        flags = 2'b10;
      end else if (opc == mas_pkg::OPC_LOAD_FP && f3 == mas_pkg::F3_W
                   && cfg.fp_emulation_on) begin
        len   = mas_pkg::LEN_WORD;
        flags = 2'b10;
      end else if (opc == mas_pkg::OPC_LOAD && f3 == mas_pkg::F3_H) begin
        len   = mas_pkg::LEN_HALF;
        flags = 2'b01;
      end else if (opc == mas_pkg::OPC_LOAD && f3 == mas_pkg::F3_HU) begin
        len   = mas_pkg::LEN_HALF;
      end
    end
  end

  always_comb begin
    job.len   = len;
    job.addr  = in_data.fault_address & m;
    job.data  = data;
    job.rd    = in_data.instruction[11:7];
    job.flags = flags;
    job.pc    = (pc + 64'd4) & m;
    if (in_data.action == mas_pkg::ACT_BYTE) begin
      job.op   = mas_pkg::JOB_BYTE;
      job.data = {56'h0, in_data.loaded_byte};
    end else if (len == mas_pkg::LEN_NONE) begin
      job.op = mas_pkg::JOB_ILLEGAL;
      job.pc = pc;
    end else if (in_data.trap_is_store) begin
      job.op = mas_pkg::JOB_WRITE;
    end else begin
      job.op = mas_pkg::JOB_READ;
    end
  end

endmodule

>>> sv/mas_fifo.sv
// ----------------------------------------------------------------------------
// mas_fifo
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module mas_fifo #(
  parameter int DEPTH = mas_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mas_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output mas_pkg::job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mas_pkg::job_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/mas_back.sv
// ----------------------------------------------------------------------------
// mas_back
// Carries out queued jobs: byte sequencing, load collection, writeback.
// ----------------------------------------------------------------------------
module mas_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mas_pkg::cfg_t      cfg,
  input  logic               head_valid,
  input  mas_pkg::job_t      head,
  output logic               head_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output mas_pkg::out_item_t out_data
);

  localparam int IW = mas_pkg::BYTE_IDX_W;
  localparam int LW = mas_pkg::LEN_W;

  logic [IW-1:0] idx_r, idx_nxt;
  logic          collecting_r, collecting_nxt;
  logic [LW-1:0] acc_len_r, acc_len_nxt;
  logic [LW-1:0] rcvd_r, rcvd_nxt;
  logic [63:0]   asm_r, asm_nxt;
  logic [4:0]    dest_r, dest_nxt;
  logic [1:0]    flags_r, flags_nxt;
  logic [63:0]   spc_r, spc_nxt;
  logic          out_valid_r;
  mas_pkg::out_item_t out_r, res;

  logic          emit;
  logic          emit_ok;
  logic          seq_last;
  logic [63:0]   m;
  logic [63:0]   asm_ins;
  logic [63:0]   int_val;

  assign m         = mas_pkg::xmask(cfg.xlen_is_64);
  assign emit_ok   = !out_valid_r || out_pop;
  assign seq_last  = ({1'b0, idx_r} + LW'(1)) == head.len;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  // returned byte dropped into its lane
  always_comb begin
    asm_ins = asm_r;
    asm_ins[{rcvd_r[IW-1:0], 3'b000} +: 8] = head.data[7:0];
  end

  always_comb begin
    case (acc_len_r)
      mas_pkg::LEN_HALF:
        int_val = {{48{flags_r[mas_pkg::FLAG_SIGNED] & asm_ins[15]}}, asm_ins[15:0]};
      mas_pkg::LEN_WORD:
        int_val = {{32{flags_r[mas_pkg::FLAG_SIGNED] & asm_ins[31]}}, asm_ins[31:0]};
      default:
        int_val = asm_ins;
    endcase
  end

  always_comb begin
    idx_nxt        = idx_r;
    collecting_nxt = collecting_r;
    acc_len_nxt    = acc_len_r;
    rcvd_nxt       = rcvd_r;
    asm_nxt        = asm_r;
    dest_nxt       = dest_r;
    flags_nxt      = flags_r;
    spc_nxt        = spc_r;
    emit           = 1'b0;
    head_pop       = 1'b0;
    res            = '0;
    if (head_valid) begin
      case (head.op)
        mas_pkg::JOB_WRITE, mas_pkg::JOB_READ: begin
          if (emit_ok) begin
            emit               = 1'b1;
            res.result_kind    = (head.op == mas_pkg::JOB_WRITE) ? mas_pkg::KIND_WRITE
                                                                 : mas_pkg::KIND_READ;
            res.byte_address   = (head.addr + 64'(idx_r)) & m;
            res.resume_pc      = head.pc;
            res.last           = seq_last;
            if (head.op == mas_pkg::JOB_WRITE) begin
              res.byte_to_write = head.data[{idx_r, 3'b000} +: 8];
            end
            if (idx_r == '0) begin
              // a new start drops any unfinished load
              collecting_nxt = head.op == mas_pkg::JOB_READ;
              acc_len_nxt    = head.len;
              rcvd_nxt       = '0;
              asm_nxt        = '0;
              dest_nxt       = head.rd;
              flags_nxt      = head.flags;
              spc_nxt        = head.pc;
            end
            if (seq_last) begin
              idx_nxt  = '0;
              head_pop = 1'b1;
            end else begin
              idx_nxt = idx_r + IW'(1);
            end
          end
        end
        mas_pkg::JOB_ILLEGAL: begin
          if (emit_ok) begin
            emit            = 1'b1;
            head_pop        = 1'b1;
            collecting_nxt  = 1'b0;
            res.result_kind = mas_pkg::KIND_ILLEGAL;
            res.resume_pc   = head.pc;
            res.last        = 1'b1;
          end
        end
        mas_pkg::JOB_BYTE: begin
          if (!collecting_r) begin
            head_pop = 1'b1;
          end else if ((rcvd_r + LW'(1)) != acc_len_r) begin
            head_pop = 1'b1;
            asm_nxt  = asm_ins;
            rcvd_nxt = rcvd_r + LW'(1);
          end else if (emit_ok) begin
            head_pop          = 1'b1;
            emit              = 1'b1;
            collecting_nxt    = 1'b0;
            asm_nxt           = asm_ins;
            rcvd_nxt          = rcvd_r + LW'(1);
            res.dest_register = dest_r;
            res.resume_pc     = spc_r;
            res.last          = 1'b1;
            if (flags_r[mas_pkg::FLAG_FP]) begin
              res.result_kind     = mas_pkg::KIND_FP_WB;
              res.fp_is_double    = acc_len_r == mas_pkg::LEN_DOUBLE;
              res.writeback_value = (acc_len_r == mas_pkg::LEN_DOUBLE) ? asm_ins
                                    : {32'h0, asm_ins[31:0]};
            end else begin
              res.result_kind     = mas_pkg::KIND_INT_WB;
              res.writeback_value = int_val & m;
            end
          end
        end
        default: begin
          head_pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      collecting_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      idx_r        <= idx_nxt;
      collecting_r <= collecting_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_len_r <= acc_len_nxt;
    rcvd_r    <= rcvd_nxt;
    asm_r     <= asm_nxt;
    dest_r    <= dest_nxt;
    flags_r   <= flags_nxt;
    spc_r     <= spc_nxt;
    if (emit) begin
      out_r <= res;
    end
  end

  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    collecting_r |-> (acc_len_r == mas_pkg::LEN_HALF || acc_len_r == mas_pkg::LEN_WORD
                      || acc_len_r == mas_pkg::LEN_DOUBLE))
    else $error("collecting with bad access length");

  a_rcvd_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    collecting_r |-> rcvd_r < acc_len_r)
    else $error("byte count reached length while still collecting");

  a_seq_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> (head_valid && (head.op == mas_pkg::JOB_WRITE
                                      || head.op == mas_pkg::JOB_READ)))
    else $error("byte sequence in flight without a sequenced job");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> ($stable(out_r) && out_valid_r))
    else $error("waiting result overwritten");

endmodule

>>> sv/misaligned_access_splitter_core.sv
// ----------------------------------------------------------------------------
// misaligned_access_splitter_core
// Emulates misaligned load and store traps as single byte transfers.
//
// Input queue (in_push / in_full): a start item carries the trap, a byte
// item returns one loaded byte for the read being collected.
// Result queue (out_empty / out_pop): byte reads, byte writes, register
// writebacks and illegal reports, oldest first, last set on the final
// result of an input.
// Config (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready; the
// user must write it only while nothing is in flight (not enforced here).
// A two-entry job queue parts the decode front from the sequencing back.
// A start's first result passes through the job queue and the result
// register; the back sequencer then gives one byte transfer per cycle
// while the result register is free, over the 2 to 8 bytes of a trap.
// Byte items retire one per cycle; the final one waits for a free result
// register and loads the writeback into it. A stalled result queue stalls
// the sequencer; the job queue then fills and in_full rises. Reset empties
// both queues, drops any collection and sets both config bits to 1.
// ----------------------------------------------------------------------------
module misaligned_access_splitter_core #(
  parameter int QUEUE_DEPTH = mas_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  mas_pkg::in_item_t                in_data,
  output logic                             out_empty,
  input  logic                             out_pop,
  output mas_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mas_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic                             cfg_data
);

  mas_pkg::cfg_t cfg_r;
  mas_pkg::job_t job;
  mas_pkg::job_t head;
  logic          job_push;
  logic          queue_full;
  logic          head_valid;
  logic          head_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.xlen_is_64      <= 1'b1;
      cfg_r.fp_emulation_on <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        mas_pkg::CFG_XLEN_IS_64:      cfg_r.xlen_is_64      <= cfg_data;
        mas_pkg::CFG_FP_EMULATION_ON: cfg_r.fp_emulation_on <= cfg_data;
        default: ;
      endcase
    end
  end

  mas_front u_front (
    .cfg        (cfg_r),
    .in_push    (in_push),
    .in_data    (in_data),
    .in_full    (in_full),
    .queue_full (queue_full),
    .job_push   (job_push),
    .job        (job)
  );

  mas_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  (job),
    .full       (queue_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mas_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

endmodule

>>> test/misaligned_access_splitter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// misaligned_access_splitter_checker
// Watches the trap, result and config channels of the splitter. Keeps its
// own copy of the mode bits and the load collection state, works out the
// byte transfers and writebacks that each accepted input should cause, and
// compares every popped result with the oldest one still owed.
// ----------------------------------------------------------------------------
module misaligned_access_splitter_checker
  import mas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  logic                   in_full,
  input  in_item_t               in_data,
  input  logic                   out_empty,
  input  logic                   out_pop,
  input  out_item_t              out_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic                   cfg_data,
  output int                     mismatch_count,
  output int                     pending_count
);

  localparam int MAX_PRINTED = 30;

  // mode bits as last written
  logic xlen_64;
  logic fp_on;

  // load being gathered
  logic             collecting;
  logic [LEN_W-1:0] access_len;
  logic [LEN_W-1:0] bytes_got;
  logic [63:0]      gathered;
  logic [4:0]       saved_rd;
  logic [1:0]       ld_flags;
  logic [63:0]      saved_resume;

  out_item_t expected_transfers[$];
  out_item_t want;
  int        mismatch_total = 0;
  int        results_seen = 0;

  task automatic report_mismatch(input string msg);
    mismatch_total++;
    // keep the log short when the block is badly broken
    if (mismatch_total <= MAX_PRINTED)
      $display("mismatch at %0t ns, result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s is %h, expected %h", name, got, exp_val));
  endtask

  task automatic emulate_trap_step(input in_item_t it);
    logic [63:0]      m;
    logic [63:0]      addr;
    logic [63:0]      resume;
    logic [63:0]      data;
    logic [63:0]      v;
    logic [63:0]      lowmask;
    logic [6:0]       opc;
    logic [2:0]       f3;
    logic [LEN_W-1:0] len;
    logic [1:0]       flags;
    int unsigned      bits;
    out_item_t        r;
    m = xlen_64 ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
    if (it.action == ACT_START) begin
      opc = it.instruction[6:0];
      f3 = it.instruction[14:12];
      addr = it.fault_address & m;
      resume = (it.trap_pc + 64'd4) & m;
      len = LEN_NONE;
      flags = '0;
      data = '0;
      // any start drops an unfinished load
      collecting = 1'b0;
      if (it.trap_is_store) begin
        if (opc == OPC_STORE && f3 == F3_W) begin
          len = LEN_WORD;
          data = it.int_source_value & m;
        end else if (opc == OPC_STORE && f3 == F3_D && xlen_64) begin
          len = LEN_DOUBLE;
          data = it.int_source_value & m;
        end else if (opc == OPC_STORE_FP && f3 == F3_D && fp_on) begin
          len = LEN_DOUBLE;
          data = it.fp_source_value;
        end else if (opc == OPC_STORE_FP && f3 == F3_W && fp_on) begin
          len = LEN_WORD;
          data = it.fp_source_value;
        end else if (opc == OPC_STORE && f3 == F3_H) begin
          len = LEN_HALF;
          data = it.int_source_value & m;
        end
      end else begin
        if (opc == OPC_LOAD && f3 == F3_W) begin
          len = LEN_WORD;
          flags[FLAG_SIGNED] = 1'b1;
        end else if (opc == OPC_LOAD && f3 == F3_D && xlen_64) begin
          len = LEN_DOUBLE;
          flags[FLAG_SIGNED] = 1'b1;
        end else if (opc == OPC_LOAD && f3 == F3_WU && xlen_64) begin
          len = LEN_WORD;
        end else if (opc == OPC_LOAD_FP && f3 == F3_D && fp_on) begin
          len = LEN_DOUBLE;
          flags[FLAG_FP] = 1'b1;
        end else if (opc == OPC_LOAD_FP && f3 == F3_W && fp_on) begin
          len = LEN_WORD;
          flags[FLAG_FP] = 1'b1;
        end else if (opc == OPC_LOAD && f3 == F3_H) begin
          len = LEN_HALF;
          flags[FLAG_SIGNED] = 1'b1;
        end else if (opc == OPC_LOAD && f3 == F3_HU) begin
          len = LEN_HALF;
        end
      end

      if (len == LEN_NONE) begin
        r = '0;
        r.result_kind = KIND_ILLEGAL;
        r.resume_pc = it.trap_pc & m;
        r.last = 1'b1;
        expected_transfers.push_back(r);
      end else begin
        for (int i = 0; i < int'(len); i++) begin
          r = '0;
          r.result_kind = it.trap_is_store ? KIND_WRITE : KIND_READ;
          r.byte_address = (addr + 64'(i)) & m;
          if (it.trap_is_store)
            r.byte_to_write = data[8*i +: 8];
          r.resume_pc = resume;
          r.last = (i == int'(len) - 1);
          expected_transfers.push_back(r);
        end
        if (!it.trap_is_store) begin
          collecting = 1'b1;
          access_len = len;
          bytes_got = '0;
          gathered = '0;
          saved_rd = it.instruction[11:7];
          ld_flags = flags;
          saved_resume = resume;
        end
      end
    end else if (collecting) begin
      if (bytes_got < MAX_ACCESS_BYTES) begin
        gathered = gathered | (64'(it.loaded_byte) << (8 * bytes_got));
        bytes_got = bytes_got + 1'b1;
      end
      if (bytes_got >= access_len) begin
        collecting = 1'b0;
        r = '0;
        r.dest_register = saved_rd;
        r.resume_pc = saved_resume;
        r.last = 1'b1;
        if (ld_flags[FLAG_FP]) begin
          r.result_kind = KIND_FP_WB;
          r.fp_is_double = (access_len == LEN_DOUBLE);
          r.writeback_value = r.fp_is_double ? gathered : {32'h0, gathered[31:0]};
        end else begin
          v = gathered;
          bits = 8 * access_len;
          if (bits < 64) begin
            lowmask = (64'd1 << bits) - 64'd1;
            v = v & lowmask;
            if (ld_flags[FLAG_SIGNED] && v[bits-1])
              v = v | ~lowmask;
          end
          r.result_kind = KIND_INT_WB;
          r.writeback_value = v & m;
        end
        expected_transfers.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      xlen_64 = 1'b1;
      fp_on = 1'b1;
      collecting = 1'b0;
      access_len = '0;
      bytes_got = '0;
      gathered = '0;
      saved_rd = '0;
      ld_flags = '0;
      saved_resume = '0;
      expected_transfers.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_XLEN_IS_64:      xlen_64 = cfg_data;
          CFG_FP_EMULATION_ON: fp_on = cfg_data;
          default: ;
        endcase
      end
      // results first: nothing accepted at this edge can already be out
      if (out_pop && !out_empty) begin
        results_seen++;
        if (expected_transfers.size() == 0) begin
          report_mismatch($sformatf("kind %0d popped with nothing owed",
                                    out_data.result_kind));
        end else begin
          want = expected_transfers.pop_front();
          check_field("result_kind", out_data.result_kind, want.result_kind);
          check_field("byte_address", out_data.byte_address, want.byte_address);
          check_field("byte_to_write", out_data.byte_to_write, want.byte_to_write);
          check_field("dest_register", out_data.dest_register, want.dest_register);
          check_field("writeback_value", out_data.writeback_value,
                      want.writeback_value);
          check_field("fp_is_double", out_data.fp_is_double, want.fp_is_double);
          check_field("resume_pc", out_data.resume_pc, want.resume_pc);
          check_field("last", out_data.last, want.last);
        end
      end
      if (in_push && !in_full)
        emulate_trap_step(in_data);
    end
    mismatch_count <= mismatch_total;
    pending_count <= expected_transfers.size();
  end

endmodule

>>> test/misaligned_access_splitter_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// misaligned_access_splitter_core_test
// Drives load and store traps and returned load bytes into the splitter
// under several mode settings and idling patterns, including a long result
// hold-off that backs the block up. The checker alongside judges every
// result; this module only makes traffic and gives the verdict.
// ----------------------------------------------------------------------------
module misaligned_access_splitter_core_test;
  import mas_pkg::*;

  localparam int          DRAIN_CYCLES    = 24;
  localparam int          HOLD_OFF_CYCLES = 300;
  // limit on run length; an honest run stays well below it
  localparam int unsigned CYCLE_LIMIT     = 400000;

  typedef enum int unsigned {
    FORM_LH, FORM_LHU, FORM_LW, FORM_LWU, FORM_LD, FORM_FLW, FORM_FLD,
    FORM_SH, FORM_SW, FORM_SD, FORM_FSW, FORM_FSD, FORM_COUNT
  } access_form_t;

  typedef struct {
    logic        store;
    logic [6:0]  opc;
    logic [2:0]  f3;
    int unsigned nbytes;
    bit          wide;
    bit          fp;
  } form_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_push = 1'b0;
  logic                   in_full;
  in_item_t               in_data = '0;
  logic                   out_empty;
  logic                   out_pop = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_XLEN_IS_64;
  logic                   cfg_data = 1'b0;
  int                     mismatches;
  int                     outstanding;

  logic        mode_wide = 1'b1;
  logic        mode_fp = 1'b1;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_req_q = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  misaligned_access_splitter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  misaligned_access_splitter_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_data        (in_data),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches),
    .pending_count  (outstanding)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off per request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      hold_left <= 0;
      hold_req_q <= 1'b0;
    end else begin
      hold_req_q <= hold_req;
      if (hold_req && !hold_req_q) begin
        hold_left <= HOLD_OFF_CYCLES;
        out_pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic form_t form_of(input access_form_t fe);
    case (fe)
      FORM_LH:  form_of = '{1'b0, OPC_LOAD,     F3_H,  int'(LEN_HALF),   1'b0, 1'b0};
      FORM_LHU: form_of = '{1'b0, OPC_LOAD,     F3_HU, int'(LEN_HALF),   1'b0, 1'b0};
      FORM_LW:  form_of = '{1'b0, OPC_LOAD,     F3_W,  int'(LEN_WORD),   1'b0, 1'b0};
      FORM_LWU: form_of = '{1'b0, OPC_LOAD,     F3_WU, int'(LEN_WORD),   1'b1, 1'b0};
      FORM_LD:  form_of = '{1'b0, OPC_LOAD,     F3_D,  int'(LEN_DOUBLE), 1'b1, 1'b0};
      FORM_FLW: form_of = '{1'b0, OPC_LOAD_FP,  F3_W,  int'(LEN_WORD),   1'b0, 1'b1};
      FORM_FLD: form_of = '{1'b0, OPC_LOAD_FP,  F3_D,  int'(LEN_DOUBLE), 1'b0, 1'b1};
      FORM_SW:  form_of = '{1'b1, OPC_STORE,    F3_W,  int'(LEN_WORD),   1'b0, 1'b0};
      FORM_SD:  form_of = '{1'b1, OPC_STORE,    F3_D,  int'(LEN_DOUBLE), 1'b1, 1'b0};
      FORM_FSW: form_of = '{1'b1, OPC_STORE_FP, F3_W,  int'(LEN_WORD),   1'b0, 1'b1};
      FORM_FSD: form_of = '{1'b1, OPC_STORE_FP, F3_D,  int'(LEN_DOUBLE), 1'b0, 1'b1};
      default:  form_of = '{1'b1, OPC_STORE,    F3_H,  int'(LEN_HALF),   1'b0, 1'b0};
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    rand64 = {$urandom, $urandom};
  endfunction

  // mostly addresses that sit near a wrap point
  function automatic logic [63:0] pick_addr();
    case ($urandom_range(3))
      0:       pick_addr = rand64();
      1:       pick_addr = {32'h0, 32'hFFFF_FFF8 | 32'($urandom_range(7))};
      2:       pick_addr = {32'hFFFF_FFFF, 32'hFFFF_FFF8 | 32'($urandom_range(7))};
      default: pick_addr = {$urandom, 32'hFFFF_FFF8 | 32'($urandom_range(7))};
    endcase
  endfunction

  function automatic logic [31:0] make_insn(input access_form_t fe, input logic [4:0] rd);
    form_t       f;
    logic [31:0] w;
    f = form_of(fe);
    w = $urandom;
    w[6:0] = f.opc;
    w[11:7] = rd;
    w[14:12] = f.f3;
    make_insn = w;
  endfunction

  task automatic push_item(input in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_data <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic send_start(input logic store, input logic [31:0] insn,
                            input logic [63:0] addr, input logic [63:0] pc,
                            input logic [63:0] ival, input logic [63:0] fval);
    in_item_t it;
    it.action = ACT_START;
    it.trap_is_store = store;
    it.instruction = insn;
    it.fault_address = addr;
    it.trap_pc = pc;
    it.int_source_value = ival;
    it.fp_source_value = fval;
    it.loaded_byte = 8'($urandom);
    push_item(it);
  endtask

  task automatic return_byte(input logic [7:0] b);
    in_item_t it;
    it.action = ACT_BYTE;
    it.trap_is_store = 1'($urandom);
    it.instruction = $urandom;
    it.fault_address = rand64();
    it.trap_pc = rand64();
    it.int_source_value = rand64();
    it.fp_source_value = rand64();
    it.loaded_byte = b;
    push_item(it);
  endtask

  // wait until every owed result is out and the back end has gone quiet
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_modes(input logic wide, input logic fp);
    cfg_index <= CFG_XLEN_IS_64;
    cfg_data <= wide;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_FP_EMULATION_ON;
    cfg_data <= fp;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_wide = wide;
    mode_fp = fp;
  endtask

  task automatic run_traffic(input int unsigned n);
    int unsigned  sent;
    int unsigned  pick;
    int unsigned  nb;
    access_form_t fe;
    form_t        f;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      fe = access_form_t'($urandom_range(FORM_COUNT - 1));
      f = form_of(fe);
      if (pick < 72) begin
        // well-formed trap; loads get their bytes back, now and then cut short
        send_start(f.store, make_insn(fe, 5'($urandom)), pick_addr(), pick_addr(),
                   rand64(), rand64());
        sent++;
        if (!f.store && (!f.wide || mode_wide) && (!f.fp || mode_fp)) begin
          nb = ($urandom_range(9) == 0) ? $urandom_range(f.nbytes - 1) : f.nbytes;
          repeat (nb) begin
            return_byte(8'($urandom));
            sent++;
          end
        end
      end else if (pick < 84) begin
        // right form, wrong kind of trap
        send_start(!f.store, make_insn(fe, 5'($urandom)), pick_addr(), pick_addr(),
                   rand64(), rand64());
        sent++;
      end else if (pick < 94) begin
        send_start(1'($urandom), $urandom, rand64(), rand64(), rand64(), rand64());
        sent++;
      end else begin
        // usually a stray byte with nothing collecting
        return_byte(8'($urandom));
        sent++;
      end
    end
  endtask

  task automatic run_phase(input logic wide, input logic fp, input int send_pct,
                           input int recv_pct, input bit hold, input int unsigned n);
    settle();
    program_modes(wide, fp);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    if (hold)
      hold_req <= 1'b1;
    run_traffic(n);
    hold_req <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stores of every width, at the edges of the address and data ranges
    send_start(1'b1, make_insn(FORM_SH, 5'd3), '1, '1, '1, rand64());
    send_start(1'b1, make_insn(FORM_SW, 5'd0), 64'h1, 64'h1000,
               64'h8877_6655_4433_2211, '1);
    send_start(1'b1, make_insn(FORM_SD, 5'd31), 64'hFFFF_FFFF_FFFF_FFFD, '0,
               64'h0123_4567_89AB_CDEF, '0);
    send_start(1'b1, make_insn(FORM_FSW, 5'd7), 64'h0000_0000_FFFF_FFFF,
               64'hFFFF_FFFF_FFFF_FFFC, '0, 64'hDEAD_BEEF_CAFE_F00D);
    send_start(1'b1, make_insn(FORM_FSD, 5'd9), '0, 64'h7FFF_FFFF_FFFF_FFFF, '0, '1);
    // signed half into x0, negative
    send_start(1'b0, make_insn(FORM_LH, 5'd0), '1, '1, rand64(), rand64());
    return_byte(8'h00);
    return_byte(8'h80);
    send_start(1'b0, make_insn(FORM_LHU, 5'd31), 64'h3, 64'h2000, rand64(), rand64());
    return_byte(8'hFF);
    return_byte(8'hFF);
    // double load abandoned by a new trap part way through
    send_start(1'b0, make_insn(FORM_LD, 5'd5), 64'h5, 64'h3000, rand64(), rand64());
    return_byte(8'hA5);
    send_start(1'b0, make_insn(FORM_FLW, 5'd12), 64'h7, 64'h4000, rand64(), rand64());
    return_byte(8'h11);
    return_byte(8'h22);
    return_byte(8'h33);
    return_byte(8'hC4);
    return_byte(8'h5A);
    send_start(1'b1, make_insn(FORM_LW, 5'd1), 64'h9, 64'h5000, rand64(), rand64());
    // an illegal start ends the collection, the byte after it is dropped
    send_start(1'b0, make_insn(FORM_LW, 5'd2), 64'hB, 64'h6000, rand64(), rand64());
    send_start(1'b0, 32'h0000_0000, 64'hD, 64'h7000, rand64(), rand64());
    return_byte(8'hFF);
    send_start(1'b0, make_insn(FORM_LWU, 5'd4), 64'hF, 64'h8000, rand64(), rand64());
    send_start(1'b0, make_insn(FORM_FLD, 5'd6), 64'h11, 64'h9000, rand64(), rand64());
    send_start(1'b0, make_insn(FORM_SD, 5'd8), 64'h13, 64'hA000, rand64(), rand64());

    run_phase(1'b1, 1'b1, 0, 0, 1'b0, 55);
    run_phase(1'b0, 1'b1, 53, 0, 1'b0, 65);
    run_phase(1'b1, 1'b0, 0, 53, 1'b0, 65);
    run_phase(1'b0, 1'b0, 33, 33, 1'b0, 65);
    run_phase(1'b1, 1'b1, 0, 0, 1'b1, 55);
    run_phase(1'b1, 1'b1, 33, 33, 1'b0, 79);
    settle();

    if (mismatches == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
